[src/sgmd_pkg.sv]
// Shared types, constants and the arctangent table of the Sobel gradient block.
package sgmd_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 11;
  localparam int GRAD_W       = 11;
  localparam int MAG_W        = 11;
  localparam int DIR_W        = 15;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MAX   = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_GRAD,
    ST_KICK,
    ST_MATH,
    ST_OUT
  } state_t;

  // Start request shared by the magnitude and the direction units.
  typedef struct packed {
    logic                     start;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } math_req_t;

  // Integer square root, one result bit per cycle.
  localparam int                SQ_W     = 21;
  localparam logic [SQ_W-1:0]   SQRT_TOP = 21'h100000;

  // CORDIC vectoring in Q32 radians.
  localparam int CORDIC_STEPS = 32;
  localparam int STEP_W       = 5;
  localparam int CX_W         = 46;
  localparam int CZ_W         = 35;
  localparam int DIR_SHIFT    = 20;
  localparam logic signed [CZ_W-1:0] PI_Q32  = 35'sd13493037705;
  localparam logic signed [CZ_W-1:0] DIR_RND = 35'sd524288;

  localparam logic [63:0] ONE = 64'd1;
  localparam logic [63:0] RND = 64'd1 << 27;

  // atan(2^-i) from the alternating series in Q60, rounded to Q32.
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'hC90FDAA2,
    32'(((ONE << 59) - (ONE << 57) / 3 + (ONE << 55) / 5 - (ONE << 53) / 7
        + (ONE << 51) / 9 - (ONE << 49) / 11 + (ONE << 47) / 13 - (ONE << 45) / 15
        + (ONE << 43) / 17 - (ONE << 41) / 19 + (ONE << 39) / 21 - (ONE << 37) / 23
        + (ONE << 35) / 25 - (ONE << 33) / 27 + (ONE << 31) / 29 - (ONE << 29) / 31
        + (ONE << 27) / 33 - (ONE << 25) / 35 + (ONE << 23) / 37 - (ONE << 21) / 39
        + (ONE << 19) / 41 - (ONE << 17) / 43 + (ONE << 15) / 45 - (ONE << 13) / 47
        + (ONE << 11) / 49 - (ONE << 9) / 51 + (ONE << 7) / 53 - (ONE << 5) / 55
        + (ONE << 3) / 57 - (ONE << 1) / 59 + RND) >> 28),
    32'(((ONE << 58) - (ONE << 54) / 3 + (ONE << 50) / 5 - (ONE << 46) / 7
        + (ONE << 42) / 9 - (ONE << 38) / 11 + (ONE << 34) / 13 - (ONE << 30) / 15
        + (ONE << 26) / 17 - (ONE << 22) / 19 + (ONE << 18) / 21 - (ONE << 14) / 23
        + (ONE << 10) / 25 - (ONE << 6) / 27 + (ONE << 2) / 29 + RND) >> 28),
    32'(((ONE << 57) - (ONE << 51) / 3 + (ONE << 45) / 5 - (ONE << 39) / 7
        + (ONE << 33) / 9 - (ONE << 27) / 11 + (ONE << 21) / 13 - (ONE << 15) / 15
        + (ONE << 9) / 17 - (ONE << 3) / 19 + RND) >> 28),
    32'(((ONE << 56) - (ONE << 48) / 3 + (ONE << 40) / 5 - (ONE << 32) / 7
        + (ONE << 24) / 9 - (ONE << 16) / 11 + (ONE << 8) / 13 - ONE / 15 + RND) >> 28),
    32'(((ONE << 55) - (ONE << 45) / 3 + (ONE << 35) / 5 - (ONE << 25) / 7
        + (ONE << 15) / 9 - (ONE << 5) / 11 + RND) >> 28),
    32'(((ONE << 54) - (ONE << 42) / 3 + (ONE << 30) / 5 - (ONE << 18) / 7
        + (ONE << 6) / 9 + RND) >> 28),
    32'(((ONE << 53) - (ONE << 39) / 3 + (ONE << 25) / 5 - (ONE << 11) / 7 + RND) >> 28),
    32'(((ONE << 52) - (ONE << 36) / 3 + (ONE << 20) / 5 - (ONE << 4) / 7 + RND) >> 28),
    32'(((ONE << 51) - (ONE << 33) / 3 + (ONE << 15) / 5 + RND) >> 28),
    32'(((ONE << 50) - (ONE << 30) / 3 + (ONE << 10) / 5 + RND) >> 28),
    32'(((ONE << 49) - (ONE << 27) / 3 + (ONE << 5) / 5 + RND) >> 28),
    32'(((ONE << 48) - (ONE << 24) / 3 + ONE / 5 + RND) >> 28),
    32'(((ONE << 47) - (ONE << 21) / 3 + RND) >> 28),
    32'(((ONE << 46) - (ONE << 18) / 3 + RND) >> 28),
    32'(((ONE << 45) - (ONE << 15) / 3 + RND) >> 28),
    32'(((ONE << 44) - (ONE << 12) / 3 + RND) >> 28),
    32'(((ONE << 43) - (ONE << 9) / 3 + RND) >> 28),
    32'(((ONE << 42) - (ONE << 6) / 3 + RND) >> 28),
    32'(((ONE << 41) - (ONE << 3) / 3 + RND) >> 28),
    32'(((ONE << 40) - ONE / 3 + RND) >> 28),
    32'(ONE << 11), 32'(ONE << 10), 32'(ONE << 9), 32'(ONE << 8),
    32'(ONE << 7),  32'(ONE << 6),  32'(ONE << 5), 32'(ONE << 4),
    32'(ONE << 3),  32'(ONE << 2),  32'(ONE << 1)
  };

endpackage

[src/sgmd_pix_if.sv]
// Pixel input channel: valid, ready and one grey pixel per beat.
interface sgmd_pix_if;
  import sgmd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

[src/sgmd_res_if.sv]
// Result channel: one gradient result per beat.
interface sgmd_res_if;
  import sgmd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ROW_W-1:0]         row;
  logic [COL_W-1:0]         col;
  logic signed [GRAD_W-1:0] grad_x;
  logic signed [GRAD_W-1:0] grad_y;
  logic [MAG_W-1:0]         magnitude;
  logic signed [DIR_W-1:0]  direction;
  logic                     last;

  modport source (output valid, output row, output col, output grad_x, output grad_y,
                  output magnitude, output direction, output last, input ready);
  modport sink   (input valid, input row, input col, input grad_x, input grad_y,
                  input magnitude, input direction, input last, output ready);
endinterface

[src/sgmd_line_mem.sv]
// Two line memories holding the row above and the row two above.
module sgmd_line_mem #(
  parameter int DEPTH = 2048
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [sgmd_pkg::PIX_W-1:0]    rd_above,
  output logic [sgmd_pkg::PIX_W-1:0]    rd_two,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [sgmd_pkg::PIX_W-1:0]    wr_above,
  input  logic [sgmd_pkg::PIX_W-1:0]    wr_two
);
  import sgmd_pkg::*;

  logic [PIX_W-1:0] above_mem [DEPTH];
  logic [PIX_W-1:0] two_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr] <= wr_above;
      two_mem[wr_addr]   <= wr_two;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_above <= above_mem[rd_addr];
      rd_two   <= two_mem[rd_addr];
    end
  end
endmodule

[src/sgmd_mag.sv]
// Gradient magnitude: squares, then a bit-serial integer square root.
module sgmd_mag (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgmd_pkg::math_req_t         req,
  output logic                        done,
  output logic [sgmd_pkg::MAG_W-1:0]  magnitude
);
  import sgmd_pkg::*;

  logic signed [2*GRAD_W-1:0] gxe, gye, sqx, sqy;
  logic [SQ_W-1:0] sqx_r, sqy_r, n_r, bit_r;
  logic [SQ_W:0]   res_r, trial;
  logic sq_r, run_r, done_r;

  assign gxe   = req.gx;
  assign gye   = req.gy;
  assign sqx   = gxe * gxe;
  assign sqy   = gye * gye;
  assign trial = res_r + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r   <= 1'b0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      sq_r   <= 1'b1;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (sq_r) begin
      sq_r  <= 1'b0;
      run_r <= 1'b1;
    end else if (run_r && bit_r[0]) begin
      run_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sqx_r <= sqx[SQ_W-1:0];
      sqy_r <= sqy[SQ_W-1:0];
    end else if (sq_r) begin
      n_r   <= sqx_r + sqy_r;
      res_r <= '0;
      bit_r <= SQRT_TOP;
    end else if (run_r) begin
      if ({1'b0, n_r} >= trial) begin
        n_r   <= SQ_W'({1'b0, n_r} - trial);
        res_r <= (res_r >> 1) + {1'b0, bit_r};
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done      = done_r;
  assign magnitude = res_r[MAG_W-1:0];
endmodule

[src/sgmd_cordic.sv]
// Gradient direction: 32-step CORDIC vectoring on |gx|, |gy| and quadrant fix-up.
module sgmd_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sgmd_pkg::math_req_t                req,
  output logic                               done,
  output logic signed [sgmd_pkg::DIR_W-1:0]  direction
);
  import sgmd_pkg::*;

  logic [GRAD_W-1:0] ax, ay;
  logic signed [CX_W-1:0] x_r, y_r, dx, dy;
  logic signed [CZ_W-1:0] z_r, ang, theta0, theta1, theta_rnd;
  logic signed [DIR_W-1:0] dir_mag, dir_r;
  logic [STEP_W-1:0] step_r;
  logic run_r, fin_r, done_r;
  logic gx_neg_r, gy_neg_r, gy_zero_r;

  assign ax = req.gx[GRAD_W-1] ? $unsigned(-req.gx) : $unsigned(req.gx);
  assign ay = req.gy[GRAD_W-1] ? $unsigned(-req.gy) : $unsigned(req.gy);

  assign dx  = y_r >>> step_r;
  assign dy  = x_r >>> step_r;
  assign ang = $signed({{(CZ_W-32){1'b0}}, ATAN_TAB[step_r]});

  // Angles below zero in the first quadrant are clipped; gx < 0 mirrors about pi/2.
  assign theta0    = (gy_zero_r || z_r[CZ_W-1]) ? '0 : z_r;
  assign theta1    = gx_neg_r ? PI_Q32 - theta0 : theta0;
  assign theta_rnd = theta1 + DIR_RND;
  assign dir_mag   = $signed(theta_rnd[CZ_W-1:DIR_SHIFT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      run_r  <= 1'b1;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (run_r) begin
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        run_r <= 1'b0;
        fin_r <= 1'b1;
      end
    end else if (fin_r) begin
      fin_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r       <= $signed({{(CX_W-GRAD_W-32){1'b0}}, ax, 32'd0});
      y_r       <= $signed({{(CX_W-GRAD_W-32){1'b0}}, ay, 32'd0});
      z_r       <= '0;
      step_r    <= '0;
      gx_neg_r  <= req.gx[GRAD_W-1];
      gy_neg_r  <= req.gy[GRAD_W-1];
      gy_zero_r <= (req.gy == '0);
    end else if (run_r) begin
      if (!y_r[CX_W-1]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end
      step_r <= step_r + 1'b1;
    end else if (fin_r) begin
      dir_r <= gy_neg_r ? -dir_mag : dir_mag;
    end
  end

  assign done      = done_r;
  assign direction = dir_r;
endmodule

[src/sobel_gradient_mag_dir_unit.sv]
// Top level of the 3x3 Sobel gradient, magnitude and direction block.
//
// Pixels enter on in_ch in raster order, one beat per pixel, starting at the
// top-left corner of the frame. Results leave on out_ch, one beat per centre
// pixel, carrying its row and column, both Sobel sums, the magnitude and the
// direction in radians times 4096. Borders replicate the nearest edge pixel.
// A pixel releases zero to four centres; last marks the final one it released.
// A pixel that releases no centre is done after the FETCH state; each released
// centre adds GRAD, KICK, MATH and OUT, MATH lasting the 32 iterations of the
// shared CORDIC unit (the square root runs beside it and finishes earlier).
// The next pixel is accepted while the final result still waits in the output
// register. A stalled receiver holds that register and, once the next result
// is ready, holds the block. Reset sets width 640 and height 480 and restarts
// the frame; the line memories need no clearing, as every frame writes each
// row before reading it. A register write on the cfg port restarts the frame.
module sobel_gradient_mag_dir_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [sgmd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [sgmd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  sgmd_pix_if.sink                          in_ch,
  sgmd_res_if.source                        out_ch
);
  import sgmd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // One column as it comes out of the line memories plus the new pixel.
  typedef struct packed {
    logic [PIX_W-1:0] two;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] now;
  } line_col_t;

  // One column of the window after the row clamping.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } win_col_t;

  state_t state_r, state_nxt;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [AW:0]             w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [AW-1:0]           col_cnt_r;
  logic [ROW_W-1:0]        row_cnt_r;
  logic                    col_end, row_end;

  logic [PIX_W-1:0] pix_r;
  logic [AW-1:0]    cc_r;
  logic [ROW_W-1:0] rr_r;
  logic row_lo_r, row_hi_r, col_lo_r, col_hi_r, rr_one_r, cc_one_r;
  logic sel_row_r, sel_col_r;
  line_col_t col0_r, col1_r, col2_r;

  logic [PIX_W-1:0] rd_above, rd_two;
  logic accept, mem_wr, grad_load, out_load, out_free;
  logic any_centre, more_centres;

  win_col_t wl, wm, wr;
  logic signed [GRAD_W-1:0] gx, gy, gx_r, gy_r;
  math_req_t req;
  logic mag_done, dir_done;
  logic [MAG_W-1:0] mag;
  logic signed [DIR_W-1:0] dir;
  logic [AW-1:0]    centre_col;
  logic [ROW_W-1:0] centre_row;

  logic                     out_valid_r, out_last_r;
  logic [ROW_W-1:0]         out_row_r;
  logic [COL_W-1:0]         out_col_r;
  logic signed [GRAD_W-1:0] out_gx_r, out_gy_r;
  logic [MAG_W-1:0]         out_mag_r;
  logic signed [DIR_W-1:0]  out_dir_r;

  function automatic logic signed [GRAD_W-1:0] ext(input logic [PIX_W-1:0] p);
    return $signed({{(GRAD_W-PIX_W){1'b0}}, p});
  endfunction

  // Row clamping: the centre one row up uses rows two-above, above and now;
  // the centre on the bottom row uses above, now and now again.
  function automatic win_col_t pick_rows(input line_col_t c, input logic sel_row,
                                         input logic rr_zero, input logic rr_one);
    win_col_t w;
    if (!sel_row) begin
      w.top = rr_one ? c.above : c.two;
      w.mid = c.above;
      w.bot = c.now;
    end else begin
      w.top = rr_zero ? c.now : c.above;
      w.mid = c.now;
      w.bot = c.now;
    end
    return w;
  endfunction

  // Effective frame size with out-of-range register values clamped.
  always_comb begin
    if (width_r == '0) begin
      w_eff = (AW+1)'(1);
    end else if (width_r > MAX_WIDTH) begin
      w_eff = (AW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (AW+1)'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (height_r > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = height_r;
    end
  end

  assign col_end = ({1'b0, col_cnt_r} == w_eff - (AW+1)'(1));
  assign row_end = (HEIGHT_REG_W'(row_cnt_r) == h_eff - HEIGHT_REG_W'(1));

  assign any_centre   = (row_lo_r || row_hi_r) && (col_lo_r || col_hi_r);
  assign more_centres = (!sel_col_r && col_hi_r) || (!sel_row_r && row_hi_r);
  assign out_free     = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = any_centre ? ST_GRAD : ST_IDLE;
      ST_GRAD:  state_nxt = ST_KICK;
      ST_KICK:  state_nxt = ST_MATH;
      ST_MATH:  if (mag_done && dir_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = more_centres ? ST_GRAD : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State decode.
  always_comb begin
    in_ch.ready = 1'b0;
    mem_wr      = 1'b0;
    grad_load   = 1'b0;
    req.start   = 1'b0;
    req.gx      = gx_r;
    req.gy      = gy_r;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_FETCH: mem_wr = 1'b1;
      ST_GRAD:  grad_load = 1'b1;
      ST_KICK:  req.start = 1'b1;
      ST_OUT:   out_load = out_free;
      default:  ;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers and the frame position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_REG_W-1:0];
        default:          ;
      endcase
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_end ? '0 : row_cnt_r + 1'b1;
      end else begin
        col_cnt_r <= col_cnt_r + 1'b1;
      end
    end
  end

  // The memory read is issued at acceptance; the write-back follows in the next
  // cycle, and the state machine keeps the next read behind it.
  sgmd_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (col_cnt_r),
    .rd_above (rd_above),
    .rd_two   (rd_two),
    .wr_en    (mem_wr),
    .wr_addr  (cc_r),
    .wr_above (pix_r),
    .wr_two   (rd_above)
  );

  // Pixel capture, window columns and centre selection.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r    <= in_ch.pixel;
      cc_r     <= col_cnt_r;
      rr_r     <= row_cnt_r;
      row_lo_r <= (row_cnt_r != '0);
      row_hi_r <= row_end;
      col_lo_r <= (col_cnt_r != '0);
      col_hi_r <= col_end;
      rr_one_r <= (row_cnt_r == ROW_W'(1));
      cc_one_r <= (col_cnt_r == AW'(1));
    end
    if (mem_wr) begin
      col2_r    <= col1_r;
      col1_r    <= col0_r;
      col0_r    <= '{two: rd_two, above: rd_above, now: pix_r};
      sel_row_r <= !row_lo_r;
      sel_col_r <= !col_lo_r;
    end
    if (out_load) begin
      if (!sel_col_r && col_hi_r) begin
        sel_col_r <= 1'b1;
      end else begin
        sel_row_r <= 1'b1;
        sel_col_r <= !col_lo_r;
      end
    end
    if (grad_load) begin
      gx_r <= gx;
      gy_r <= gy;
    end
  end

  // Column clamping: the centre one column left uses columns cc-2..cc, the
  // centre on the right edge uses cc-1, cc and cc again.
  always_comb begin
    if (!sel_col_r) begin
      wl = pick_rows(cc_one_r ? col1_r : col2_r, sel_row_r, !row_lo_r, rr_one_r);
      wm = pick_rows(col1_r, sel_row_r, !row_lo_r, rr_one_r);
      wr = pick_rows(col0_r, sel_row_r, !row_lo_r, rr_one_r);
    end else begin
      wl = pick_rows(col_lo_r ? col1_r : col0_r, sel_row_r, !row_lo_r, rr_one_r);
      wm = pick_rows(col0_r, sel_row_r, !row_lo_r, rr_one_r);
      wr = wm;
    end
    gx = (ext(wr.top) + ext(wr.mid) + ext(wr.mid) + ext(wr.bot))
       - (ext(wl.top) + ext(wl.mid) + ext(wl.mid) + ext(wl.bot));
    gy = (ext(wl.bot) + ext(wm.bot) + ext(wm.bot) + ext(wr.bot))
       - (ext(wl.top) + ext(wm.top) + ext(wm.top) + ext(wr.top));
  end

  sgmd_mag u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .done      (mag_done),
    .magnitude (mag)
  );

  sgmd_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .done      (dir_done),
    .direction (dir)
  );

  assign centre_col = sel_col_r ? cc_r : cc_r - 1'b1;
  assign centre_row = sel_row_r ? rr_r : rr_r - 1'b1;

  // Output register: one result beat held until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= centre_row;
      out_col_r  <= COL_W'(centre_col);
      out_gx_r   <= gx_r;
      out_gy_r   <= gy_r;
      out_mag_r  <= mag;
      out_dir_r  <= dir;
      out_last_r <= !more_centres;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row       = out_row_r;
  assign out_ch.col       = out_col_r;
  assign out_ch.grad_x    = out_gx_r;
  assign out_ch.grad_y    = out_gy_r;
  assign out_ch.magnitude = out_mag_r;
  assign out_ch.direction = out_dir_r;
  assign out_ch.last      = out_last_r;

`ifndef SYNTHESIS
  a_fetch_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_FETCH)
    else $error("accepted pixel not followed by the memory write-back");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_cnt_r} < w_eff)
    else $error("column counter beyond the frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    HEIGHT_REG_W'(row_cnt_r) < h_eff)
    else $error("row counter beyond the frame height");

  a_mag_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (int'(out_mag_r) * int'(out_mag_r)
                     <= int'(out_gx_r) * int'(out_gx_r) + int'(out_gy_r) * int'(out_gy_r))
                 && ((int'(out_mag_r) + 1) * (int'(out_mag_r) + 1)
                     > int'(out_gx_r) * int'(out_gx_r) + int'(out_gy_r) * int'(out_gy_r)))
    else $error("magnitude is not the floor of the square root");
`endif
endmodule
